/* sv/mmpid_pkg.sv */
// Package for the multimodal position-id generator.
// Holds sizes, command/status/register codes, state types and small helpers.
// No dependencies.
`default_nettype none

package mmpid_pkg;

    // Sizing
    localparam int MAX_REFS = 10;
    localparam int DIM_MAX  = 1024;
    localparam int TEXT_MAX = 65535;

    localparam int TEXT_W   = 16;                    // text slot / length
    localparam int DIM_W    = 11;                    // image dimension
    localparam int CTR_W    = $clog2(DIM_MAX);       // row / column counter
    localparam int POS_T_W  = 17;                    // temporal position
    localparam int POS_X2_W = 19;                    // doubled row / column
    localparam int IDX_W    = 4;                     // image_index field
    localparam int CNT_W    = $clog2(MAX_REFS + 1);  // reference count
    localparam int REF_AW   = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int REF_W    = TEXT_W + 2 * DIM_W;    // one stored descriptor
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Item payload widths on the stream ports
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 3;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_START = 2'd1,
        CMD_NEXT  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_GEN   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_TEXT_LEN    = 2'd0,
        CFG_MAIN_HEIGHT = 2'd1,
        CFG_MAIN_WIDTH  = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_TEXT  = 2'd1,
        PH_IMAGE = 2'd2
    } gen_phase_t;

    typedef enum logic {
        CS_READY = 1'b0,
        CS_LOAD  = 1'b1
    } ctl_state_t;

    typedef struct packed {
        logic [TEXT_W-1:0] slot;
        logic [DIM_W-1:0]  height;
        logic [DIM_W-1:0]  width;
    } ref_entry_t;

    // Dimension in 1..DIM_MAX
    function automatic logic dim_ok(input logic [DIM_W-1:0] d);
        return (d != '0) && (d <= DIM_W'(DIM_MAX));
    endfunction

    // 2*(idx - ceil(n/2)) + n%2 - main_n%2, exact in doubled units
    function automatic logic signed [POS_X2_W-1:0] centred_x2(
        input logic [CTR_W-1:0] idx,
        input logic [DIM_W-1:0] n,
        input logic [DIM_W-1:0] main_n
    );
        logic [DIM_W:0]              half_up;
        logic signed [POS_X2_W-1:0]  v;
        half_up = ({1'b0, n} + (DIM_W+1)'(1)) >> 1;
        v = $signed(POS_X2_W'(idx) << 1) - $signed(POS_X2_W'(half_up) << 1);
        v = v + $signed(POS_X2_W'(n[0])) - $signed(POS_X2_W'(main_n[0]));
        return v;
    endfunction

endpackage

`default_nettype wire

/* sv/mmpid_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the reference descriptor table. No dependencies.
`default_nettype none

module mmpid_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/multimodal_position_id_generator.sv */
// A result is registered in the cycle after its item is accepted.
// Throughput: one item per cycle while the output is not stalled, except that starting and
// moving to the next segment pass through a descriptor table read state (one RAM port).
// Reset (rst_n, async, low): idle, empty table, text length and main size 1.
// The descriptor table is not cleared; only entries below the count are read.
// Top level of the multimodal position-id generator; uses mmpid_pkg, mmpid_ram.
`default_nettype none

module multimodal_position_id_generator (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Item in: tdata = ref_text_slot, ref_height, ref_width, zero pad
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [mmpid_pkg::S_TDATA_W-1:0]      s_tdata,
    // tuser = command
    input  wire logic [mmpid_pkg::S_TUSER_W-1:0]      s_tuser,
    // Item out: tdata = pos_temporal, pos_row_x2, pos_col_x2, segment_first,
    // image_index, zero pad
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [mmpid_pkg::M_TDATA_W-1:0]           m_tdata,
    // tuser = status, is_text
    output logic [mmpid_pkg::M_TUSER_W-1:0]           m_tuser,
    output logic                                      m_tlast,
    // Register writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [mmpid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [mmpid_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int TW  = mmpid_pkg::TEXT_W;
    localparam int DW  = mmpid_pkg::DIM_W;
    localparam int CW  = mmpid_pkg::CTR_W;
    localparam int PW  = mmpid_pkg::POS_T_W;
    localparam int XW  = mmpid_pkg::POS_X2_W;
    localparam int NW  = mmpid_pkg::CNT_W;
    localparam int AW  = mmpid_pkg::REF_AW;
    localparam int IW  = mmpid_pkg::IDX_W;

    // Input field split
    mmpid_pkg::cmd_t   in_cmd;
    logic [TW-1:0]     in_slot;
    logic [DW-1:0]     in_h;
    logic [DW-1:0]     in_w;
    logic              in_acc;

    assign in_cmd  = mmpid_pkg::cmd_t'(s_tuser[1:0]);
    assign in_slot = s_tdata[TW-1:0];
    assign in_h    = s_tdata[TW+DW-1:TW];
    assign in_w    = s_tdata[TW+2*DW-1:TW+DW];
    assign in_acc  = s_tvalid && s_tready;

    // Control state
    mmpid_pkg::ctl_state_t  state_reg, state_next;
    mmpid_pkg::gen_phase_t  phase_reg, phase_next;
    logic [NW-1:0]          ref_count_reg, ref_count_next;
    logic [TW-1:0]          last_slot_reg, last_slot_next;
    logic [NW-1:0]          seg_reg, seg_next;
    logic [TW-1:0]          cursor_reg, cursor_next;
    logic [CW-1:0]          row_reg, row_next;
    logic [CW-1:0]          col_reg, col_next;
    logic [PW-1:0]          temp_reg, temp_next;
    logic [TW-1:0]          text_len_reg, text_len_next;
    logic [DW-1:0]          main_h_reg, main_h_next;
    logic [DW-1:0]          main_w_reg, main_w_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    // Current segment descriptor (payload)
    logic [TW-1:0]          cur_end_reg, cur_end_next;
    logic [TW-1:0]          seg_start_reg, seg_start_next;
    logic [DW-1:0]          cur_h_reg, cur_h_next;
    logic [DW-1:0]          cur_w_reg, cur_w_next;

    // Result register (payload)
    mmpid_pkg::status_t     o_status_reg, o_status_next;
    logic [PW-1:0]          o_temp_reg, o_temp_next;
    logic signed [XW-1:0]   o_row_reg, o_row_next;
    logic signed [XW-1:0]   o_col_reg, o_col_next;
    logic                   o_text_reg, o_text_next;
    logic                   o_first_reg, o_first_next;
    logic [IW-1:0]          o_index_reg, o_index_next;
    logic                   o_last_reg, o_last_next;

    // Table RAM
    logic                       ram_we;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    mmpid_pkg::ref_entry_t      ram_wentry;
    logic [mmpid_pkg::REF_W-1:0] ram_rdata;
    mmpid_pkg::ref_entry_t      ram_rentry;

    assign ram_wentry.slot   = in_slot;
    assign ram_wentry.height = in_h;
    assign ram_wentry.width  = in_w;
    assign ram_rentry        = mmpid_pkg::ref_entry_t'(ram_rdata);

    mmpid_ram #(
        .WIDTH (mmpid_pkg::REF_W),
        .DEPTH (mmpid_pkg::MAX_REFS)
    ) u_ref_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ref_count_reg[AW-1:0]),
        .wdata (ram_wentry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshakes
    assign s_tready  = (state_reg == mmpid_pkg::CS_READY) && (!m_tvalid_reg || m_tready);
    assign cfg_ready = 1'b1;

    // Output packing
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tuser  = {o_text_reg, o_status_reg};
    assign m_tdata  = {4'b0000, o_index_reg, o_first_reg, o_col_reg, o_row_reg, o_temp_reg};

    // Next-state and result logic
    always_comb
    begin
        logic           seg_is_ref;
        logic           start_ok;
        logic [TW:0]    cursor_inc;
        logic [DW-1:0]  col_inc;
        logic [DW-1:0]  row_inc;
        logic [DW-1:0]  dim_max;
        logic [NW-1:0]  seg_inc;

        state_next       = state_reg;
        phase_next       = phase_reg;
        ref_count_next   = ref_count_reg;
        last_slot_next   = last_slot_reg;
        seg_next         = seg_reg;
        cursor_next      = cursor_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        temp_next        = temp_reg;
        text_len_next    = text_len_reg;
        main_h_next      = main_h_reg;
        main_w_next      = main_w_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        cur_end_next     = cur_end_reg;
        seg_start_next   = seg_start_reg;
        cur_h_next       = cur_h_reg;
        cur_w_next       = cur_w_reg;
        o_status_next    = o_status_reg;
        o_temp_next      = o_temp_reg;
        o_row_next       = o_row_reg;
        o_col_next       = o_col_reg;
        o_text_next      = o_text_reg;
        o_first_next     = o_first_reg;
        o_index_next     = o_index_reg;
        o_last_next      = o_last_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_raddr        = '0;

        seg_is_ref = (seg_reg < ref_count_reg);
        start_ok   = (text_len_reg != '0)
                     && ({1'b0, text_len_reg} <= (TW+1)'(mmpid_pkg::TEXT_MAX))
                     && mmpid_pkg::dim_ok(main_h_reg) && mmpid_pkg::dim_ok(main_w_reg)
                     && (last_slot_reg <= text_len_reg);
        cursor_inc = {1'b0, cursor_reg} + (TW+1)'(1);
        col_inc    = DW'(col_reg) + DW'(1);
        row_inc    = DW'(row_reg) + DW'(1);
        dim_max    = (cur_h_reg > cur_w_reg) ? cur_h_reg : cur_w_reg;
        seg_inc    = seg_reg + NW'(1);

        // Register writes apply only while not generating
        if (cfg_valid && (state_reg == mmpid_pkg::CS_READY)
            && (phase_reg == mmpid_pkg::PH_IDLE))
        begin
            unique case (mmpid_pkg::cfg_idx_t'(cfg_index))
                mmpid_pkg::CFG_TEXT_LEN:    text_len_next = cfg_data[TW-1:0];
                mmpid_pkg::CFG_MAIN_HEIGHT: main_h_next   = cfg_data[DW-1:0];
                mmpid_pkg::CFG_MAIN_WIDTH:  main_w_next   = cfg_data[DW-1:0];
                default: ;
            endcase
        end

        if (state_reg == mmpid_pkg::CS_LOAD)
        begin
            // Table data has arrived: set up the segment
            if (seg_is_ref)
            begin
                cur_end_next = ram_rentry.slot;
                cur_h_next   = ram_rentry.height;
                cur_w_next   = ram_rentry.width;
            end
            else
            begin
                cur_end_next = text_len_reg;
                cur_h_next   = main_h_reg;
                cur_w_next   = main_w_reg;
            end
            phase_next = (cur_end_next > cursor_reg) ? mmpid_pkg::PH_TEXT
                                                     : mmpid_pkg::PH_IMAGE;
            row_next   = '0;
            col_next   = '0;
            state_next = mmpid_pkg::CS_READY;
        end
        else if (in_acc)
        begin
            m_tvalid_next = 1'b1;
            o_status_next = mmpid_pkg::ST_OK;
            o_temp_next   = '0;
            o_row_next    = '0;
            o_col_next    = '0;
            o_text_next   = 1'b0;
            o_first_next  = 1'b0;
            o_index_next  = '0;
            o_last_next   = 1'b0;

            unique case (in_cmd)
                mmpid_pkg::CMD_ADD:
                begin
                    phase_next = mmpid_pkg::PH_IDLE;
                    if (ref_count_reg >= NW'(mmpid_pkg::MAX_REFS))
                    begin
                        o_status_next = mmpid_pkg::ST_FULL;
                    end
                    else if ((in_slot < last_slot_reg) || (in_slot > text_len_reg)
                             || !mmpid_pkg::dim_ok(in_h) || !mmpid_pkg::dim_ok(in_w))
                    begin
                        o_status_next = mmpid_pkg::ST_INVALID;
                    end
                    else
                    begin
                        ram_we         = 1'b1;
                        ref_count_next = ref_count_reg + NW'(1);
                        last_slot_next = in_slot;
                    end
                end

                mmpid_pkg::CMD_START:
                begin
                    if (!start_ok)
                    begin
                        phase_next    = mmpid_pkg::PH_IDLE;
                        o_status_next = mmpid_pkg::ST_INVALID;
                    end
                    else
                    begin
                        // Slots are stored in rising order, so last_slot bounds them all
                        seg_next       = '0;
                        cursor_next    = '0;
                        temp_next      = '0;
                        seg_start_next = '0;
                        phase_next     = mmpid_pkg::PH_TEXT;
                        state_next     = mmpid_pkg::CS_LOAD;
                        ram_re         = (ref_count_reg != '0);
                        ram_raddr      = '0;
                    end
                end

                mmpid_pkg::CMD_CLEAR:
                begin
                    phase_next     = mmpid_pkg::PH_IDLE;
                    ref_count_next = '0;
                    last_slot_next = '0;
                end

                mmpid_pkg::CMD_NEXT:
                begin
                    unique case (phase_reg)
                        mmpid_pkg::PH_TEXT:
                        begin
                            o_temp_next  = temp_reg;
                            o_row_next   = $signed(XW'(temp_reg) << 1);
                            o_col_next   = $signed(XW'(temp_reg) << 1);
                            o_text_next  = 1'b1;
                            o_first_next = (cursor_reg == seg_start_reg);
                            o_index_next = IW'(seg_reg);
                            temp_next    = temp_reg + PW'(1);
                            cursor_next  = cursor_inc[TW-1:0];
                            if (cursor_inc >= {1'b0, cur_end_reg})
                            begin
                                phase_next = mmpid_pkg::PH_IMAGE;
                            end
                        end

                        mmpid_pkg::PH_IMAGE:
                        begin
                            o_temp_next  = temp_reg;
                            o_row_next   = mmpid_pkg::centred_x2(row_reg, cur_h_reg, main_h_reg);
                            o_col_next   = mmpid_pkg::centred_x2(col_reg, cur_w_reg, main_w_reg);
                            o_first_next = (row_reg == '0) && (col_reg == '0);
                            o_index_next = IW'(seg_reg);
                            col_next     = col_inc[CW-1:0];
                            if (col_inc >= cur_w_reg)
                            begin
                                col_next = '0;
                                row_next = row_inc[CW-1:0];
                                if (row_inc >= cur_h_reg)
                                begin
                                    // Image done: advance time, then main image ends it
                                    temp_next = temp_reg + PW'(dim_max);
                                    if (!seg_is_ref)
                                    begin
                                        o_last_next = 1'b1;
                                        phase_next  = mmpid_pkg::PH_IDLE;
                                        row_next    = '0;
                                    end
                                    else
                                    begin
                                        seg_next       = seg_inc;
                                        seg_start_next = cur_end_reg;
                                        state_next     = mmpid_pkg::CS_LOAD;
                                        ram_re         = (seg_inc < ref_count_reg);
                                        ram_raddr      = seg_inc[AW-1:0];
                                    end
                                end
                            end
                        end

                        default:
                        begin
                            o_status_next = mmpid_pkg::ST_NOT_GEN;
                        end
                    endcase
                end

                default: ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= mmpid_pkg::CS_READY;
            phase_reg       <= mmpid_pkg::PH_IDLE;
            ref_count_reg   <= '0;
            last_slot_reg   <= '0;
            seg_reg         <= '0;
            cursor_reg      <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            temp_reg        <= '0;
            text_len_reg    <= TW'(1);
            main_h_reg      <= DW'(1);
            main_w_reg      <= DW'(1);
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            ref_count_reg   <= ref_count_next;
            last_slot_reg   <= last_slot_next;
            seg_reg         <= seg_next;
            cursor_reg      <= cursor_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            temp_reg        <= temp_next;
            text_len_reg    <= text_len_next;
            main_h_reg      <= main_h_next;
            main_w_reg      <= main_w_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_end_reg   <= cur_end_next;
        seg_start_reg <= seg_start_next;
        cur_h_reg     <= cur_h_next;
        cur_w_reg     <= cur_w_next;
        o_status_reg  <= o_status_next;
        o_temp_reg    <= o_temp_next;
        o_row_reg     <= o_row_next;
        o_col_reg     <= o_col_next;
        o_text_reg    <= o_text_next;
        o_first_reg   <= o_first_next;
        o_index_reg   <= o_index_next;
        o_last_reg    <= o_last_next;
    end

`ifndef SYNTHESIS
    // Table count never exceeds its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ref_count_reg <= NW'(mmpid_pkg::MAX_REFS))
        else $error("reference count above table size");

    // A clear resets the reference count on the next cycle
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_cmd == mmpid_pkg::CMD_CLEAR)) |=> (ref_count_reg == '0))
        else $error("clear did not empty the table");

    // The table read state always gives way to ready on the next cycle
    a_load_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mmpid_pkg::CS_LOAD) |=> (state_reg == mmpid_pkg::CS_READY))
        else $error("load state held more than one cycle");

    // Column and row counters stay inside the current image
    a_image_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == mmpid_pkg::CS_READY) && (phase_reg == mmpid_pkg::PH_IMAGE))
        |-> ((DW'(col_reg) < cur_w_reg) && (DW'(row_reg) < cur_h_reg)))
        else $error("image counter outside image");

    // A result flagged last leaves the generator idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_cmd == mmpid_pkg::CMD_NEXT)) ##1 o_last_reg
        |-> (phase_reg == mmpid_pkg::PH_IDLE))
        else $error("generation still running after last token");
`endif

endmodule

`default_nettype wire
